>>> sv/assert_macros.svh
// Shared assertion shorthands for the project checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("next-cycle implication failed");

`endif

>>> sv/clrs_pkg.sv
package clrs_pkg;

    parameter int ROW_CHARS_DEF    = 16;
    parameter int SCREEN_CHARS_DEF = 32;
    parameter int GLYPH_COUNT_DEF  = 8;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_SCREEN    = 2'd1,
        CMD_GLYPH_ROW = 2'd2,
        CMD_UPLOAD    = 2'd3
    } cmd_t;

    localparam logic [7:0] SPACE_CHAR    = 8'h20;
    localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
    localparam logic [7:0] LCD_SET_CGRAM = 8'h40;
    localparam logic [7:0] ROW2_ADDR     = 8'h40;
    localparam logic [2:0] LAST_ROW      = 3'd7;

    typedef enum logic [1:0] {
        SRC_CONST  = 2'd0,
        SRC_SCREEN = 2'd1,
        SRC_GLYPH  = 2'd2
    } byte_src_t;

    typedef struct packed {
        logic take;   // input word accepted this cycle
        logic load;   // move the fetched byte into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic tick;   // word at the input is a tick
    } dp_status_t;

endpackage

>>> sv/clrs_in_if.sv
interface clrs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [4:0] char_pos;
    logic [2:0] glyph;
    logic [2:0] glyph_row;
    logic [7:0] value;

    modport source (output valid, output cmd, output char_pos, output glyph,
                    output glyph_row, output value, input ready);
    modport sink   (input valid, input cmd, input char_pos, input glyph,
                    input glyph_row, input value, output ready);
endinterface

>>> sv/clrs_out_if.sv
interface clrs_out_if;
    logic       valid;
    logic       ready;
    logic       is_data;
    logic [7:0] lcd_byte;

    modport source (output valid, output is_data, output lcd_byte, input ready);
    modport sink   (input valid, input is_data, input lcd_byte, output ready);
endinterface

>>> sv/char_lcd_refresh_sequencer.sv
// Character LCD refresh sequencer. Each tick word on the input channel yields one byte
// on the output channel (is_data high for data, low for a command); screen writes, glyph
// row writes and glyph upload requests are taken and yield nothing.
// A tick holds the input off until its byte is loaded: the screen buffer and glyph
// store are synchronous memories, so the byte is read at the accepting edge and moved
// into the output register from the load state, which waits while the output register
// is stalled until it drains. Other words are taken while a byte waits at the output.
// The screen buffer reads as spaces after reset through per-entry valid flags, so no
// clearing pass is needed; glyph rows must be written before they are uploaded.
module char_lcd_refresh_sequencer #(
    parameter int ROW_CHARS    = clrs_pkg::ROW_CHARS_DEF,
    parameter int SCREEN_CHARS = clrs_pkg::SCREEN_CHARS_DEF,
    parameter int GLYPH_COUNT  = clrs_pkg::GLYPH_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    clrs_in_if.sink     in,
    clrs_out_if.source  out
);
    import clrs_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t sts;
    logic       in_ready;
    logic       out_valid;

    clrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    clrs_datapath #(
        .ROW_CHARS    (ROW_CHARS),
        .SCREEN_CHARS (SCREEN_CHARS),
        .GLYPH_COUNT  (GLYPH_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .cmd       (in.cmd),
        .char_pos  (in.char_pos),
        .glyph     (in.glyph),
        .glyph_row (in.glyph_row),
        .value     (in.value),
        .is_data   (out.is_data),
        .lcd_byte  (out.lcd_byte)
    );

    assign in.ready  = in_ready;
    assign out.valid = out_valid;

endmodule

>>> sv/clrs_ctrl.sv
module clrs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  clrs_pkg::dp_status_t   sts,
    output clrs_pkg::ctrl_cmd_t    ctl
);
    import clrs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctl.take = in_valid && in_ready;
        ctl.load = (state_reg == S_LOAD) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.take && sts.tick)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                // hold until the output register is free
                if (ctl.load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/clrs_datapath.sv
module clrs_datapath #(
    parameter int ROW_CHARS    = clrs_pkg::ROW_CHARS_DEF,
    parameter int SCREEN_CHARS = clrs_pkg::SCREEN_CHARS_DEF,
    parameter int GLYPH_COUNT  = clrs_pkg::GLYPH_COUNT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  clrs_pkg::ctrl_cmd_t    ctl,
    output clrs_pkg::dp_status_t   sts,
    input  logic [1:0]             cmd,
    input  logic [4:0]             char_pos,
    input  logic [2:0]             glyph,
    input  logic [2:0]             glyph_row,
    input  logic [7:0]             value,
    output logic                   is_data,
    output logic [7:0]             lcd_byte
);
    import clrs_pkg::*;

    localparam int POS_W       = $clog2(SCREEN_CHARS + 1);
    localparam int SCR_AW      = $clog2(SCREEN_CHARS);
    localparam int GLYPH_CELLS = GLYPH_COUNT * 8;
    localparam int GLY_AW      = $clog2(GLYPH_CELLS);

    logic [7:0] screen_mem [SCREEN_CHARS];
    logic [7:0] glyph_mem  [GLYPH_CELLS];

    logic [SCREEN_CHARS-1:0] scr_valid_reg;
    logic [SCREEN_CHARS-1:0] scr_valid_next;
    logic [GLYPH_COUNT-1:0]  pending_reg;
    logic [GLYPH_COUNT-1:0]  pending_next;
    logic [POS_W-1:0]        pos_reg;
    logic [POS_W-1:0]        pos_next;
    logic [2:0]              up_glyph_reg;
    logic [2:0]              up_glyph_next;
    logic [2:0]              up_row_reg;
    logic [2:0]              up_row_next;
    logic                    dd_sent_reg;
    logic                    dd_sent_next;
    logic                    cg_sent_reg;
    logic                    cg_sent_next;
    logic                    in_use_reg;
    logic                    in_use_next;

    // fetched byte waiting for the output register
    byte_src_t               src_reg;
    byte_src_t               src_next;
    logic [7:0]              const_reg;
    logic [7:0]              const_next;
    logic                    data_reg;
    logic                    data_next;
    logic [7:0]              scr_rd_reg;
    logic                    scr_rd_vld_reg;
    logic [7:0]              gly_rd_reg;
    logic [7:0]              out_byte_reg;
    logic                    out_data_reg;

    logic                    do_tick;
    logic                    scr_wr;
    logic                    gly_wr;
    logic                    req_wr;
    logic [SCR_AW-1:0]       scr_wr_addr;
    logic [SCR_AW-1:0]       scr_rd_addr;
    logic [GLY_AW-1:0]       gly_wr_addr;
    logic [GLY_AW-1:0]       gly_rd_addr;
    logic [POS_W-1:0]        rd_pos;
    logic [2:0]              low_glyph;
    logic [7:0]              fetched;

    assign sts.tick = (cmd == CMD_TICK);
    assign do_tick  = ctl.take && sts.tick;
    assign scr_wr   = ctl.take && (cmd == CMD_SCREEN) && (int'(char_pos) < SCREEN_CHARS);
    assign gly_wr   = ctl.take && (cmd == CMD_GLYPH_ROW) && (int'(glyph) < GLYPH_COUNT);
    assign req_wr   = ctl.take && (cmd == CMD_UPLOAD) && (int'(glyph) < GLYPH_COUNT);

    assign scr_wr_addr = SCR_AW'(char_pos);
    assign gly_wr_addr = GLY_AW'({glyph, glyph_row});
    assign gly_rd_addr = GLY_AW'({up_glyph_reg, up_row_reg});

    // the wrap case streams position 0 right after the end-of-screen command
    assign rd_pos      = (pos_reg >= POS_W'(SCREEN_CHARS)) ? '0 : pos_reg;
    assign scr_rd_addr = SCR_AW'(rd_pos);

    always_comb
    begin
        low_glyph = '0;
        for (int i = GLYPH_COUNT - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                low_glyph = 3'(i);
            end
        end
    end

    always_comb
    begin
        pending_next  = pending_reg;
        pos_next      = pos_reg;
        up_glyph_next = up_glyph_reg;
        up_row_next   = up_row_reg;
        dd_sent_next  = dd_sent_reg;
        cg_sent_next  = cg_sent_reg;
        in_use_next   = in_use_reg;
        src_next      = src_reg;
        const_next    = const_reg;
        data_next     = data_reg;

        if (do_tick)
        begin
            src_next   = SRC_CONST;
            const_next = LCD_SET_DDRAM;
            data_next  = 1'b0;
            if (pending_reg != '0)
            begin
                in_use_next = 1'b1;
                if (cg_sent_reg)
                begin
                    src_next    = SRC_GLYPH;
                    data_next   = 1'b1;
                    up_row_next = up_row_reg + 3'd1;
                    if (up_row_reg == LAST_ROW)
                    begin
                        // drop the pending bit once the last row goes out
                        for (int i = 0; i < GLYPH_COUNT; i++)
                        begin
                            if (3'(i) == up_glyph_reg)
                            begin
                                pending_next[i] = 1'b0;
                            end
                        end
                        cg_sent_next  = 1'b0;
                        up_row_next   = '0;
                        up_glyph_next = '0;
                    end
                end
                else
                begin
                    up_glyph_next = low_glyph;
                    cg_sent_next  = 1'b1;
                    const_next    = LCD_SET_CGRAM | {2'b00, low_glyph, 3'b000};
                end
            end
            else if (in_use_reg)
            begin
                in_use_next  = 1'b0;
                dd_sent_next = 1'b0;
                pos_next     = '0;
            end
            else if (pos_reg >= POS_W'(SCREEN_CHARS))
            begin
                if (dd_sent_reg)
                begin
                    dd_sent_next = 1'b0;
                    pos_next     = POS_W'(1);
                    src_next     = SRC_SCREEN;
                    data_next    = 1'b1;
                end
                else
                begin
                    dd_sent_next = 1'b1;
                end
            end
            else if (pos_reg == POS_W'(ROW_CHARS))
            begin
                if (dd_sent_reg)
                begin
                    dd_sent_next = 1'b0;
                    pos_next     = pos_reg + POS_W'(1);
                    src_next     = SRC_SCREEN;
                    data_next    = 1'b1;
                end
                else
                begin
                    dd_sent_next = 1'b1;
                    const_next   = LCD_SET_DDRAM | ROW2_ADDR;
                end
            end
            else
            begin
                pos_next  = pos_reg + POS_W'(1);
                src_next  = SRC_SCREEN;
                data_next = 1'b1;
            end
        end

        if (req_wr)
        begin
            for (int i = 0; i < GLYPH_COUNT; i++)
            begin
                if (3'(i) == glyph)
                begin
                    pending_next[i] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        scr_valid_next = scr_valid_reg;
        if (scr_wr)
        begin
            scr_valid_next[scr_wr_addr] = 1'b1;
        end
    end

    always_comb
    begin
        case (src_reg)
            SRC_SCREEN: fetched = scr_rd_vld_reg ? scr_rd_reg : SPACE_CHAR;
            SRC_GLYPH:  fetched = gly_rd_reg;
            default:    fetched = const_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (scr_wr)
        begin
            screen_mem[scr_wr_addr] <= value;
        end
        if (do_tick)
        begin
            scr_rd_reg <= screen_mem[scr_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (gly_wr)
        begin
            glyph_mem[gly_wr_addr] <= value;
        end
        if (do_tick)
        begin
            gly_rd_reg <= glyph_mem[gly_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_tick)
        begin
            scr_rd_vld_reg <= scr_valid_reg[scr_rd_addr];
        end
        src_reg   <= src_next;
        const_reg <= const_next;
        data_reg  <= data_next;
        if (ctl.load)
        begin
            out_byte_reg <= fetched;
            out_data_reg <= data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_valid_reg <= '0;
            pending_reg   <= '0;
            pos_reg       <= '0;
            up_glyph_reg  <= '0;
            up_row_reg    <= '0;
            dd_sent_reg   <= 1'b0;
            cg_sent_reg   <= 1'b0;
            in_use_reg    <= 1'b0;
        end
        else
        begin
            scr_valid_reg <= scr_valid_next;
            pending_reg   <= pending_next;
            pos_reg       <= pos_next;
            up_glyph_reg  <= up_glyph_next;
            up_row_reg    <= up_row_next;
            dd_sent_reg   <= dd_sent_next;
            cg_sent_reg   <= cg_sent_next;
            in_use_reg    <= in_use_next;
        end
    end

    assign is_data  = out_data_reg;
    assign lcd_byte = out_byte_reg;

endmodule

>>> sv/clrs_checker.sv
`include "assert_macros.svh"

module clrs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_cmd,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_is_data,
    input logic [7:0] out_lcd_byte
);
    import clrs_pkg::*;

    logic acc_tick;
    logic acc_other;

    assign acc_tick  = in_valid && in_ready && (in_cmd == CMD_TICK);
    assign acc_other = in_valid && in_ready && (in_cmd != CMD_TICK);

    // a tick blocks the input while its byte is fetched
    `ASSERT_NEXT(a_tick_busy, clk, rst_n, acc_tick, !in_ready)

    // a tick into an empty output shows its byte once the load state moves it to the output
    `ASSERT_NEXT(a_tick_byte, clk, rst_n, acc_tick && !out_valid, ##1 out_valid)

    // writes and upload requests never produce a byte
    `ASSERT_NEXT(a_write_silent, clk, rst_n, acc_other && !out_valid, !out_valid)

    // a stalled byte holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                 out_valid && $stable(out_lcd_byte) && $stable(out_is_data))

endmodule

bind char_lcd_refresh_sequencer clrs_checker u_clrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in.valid),
    .in_ready     (in.ready),
    .in_cmd       (in.cmd),
    .out_valid    (out.valid),
    .out_ready    (out.ready),
    .out_is_data  (out.is_data),
    .out_lcd_byte (out.lcd_byte)
);
